// ----- design/asa_pkg.sv -----
// ----------------------------------------------------------------------------
// asa_pkg: shared types and constants of the ADC sample aggregator
// Request formats, aggregation modes and the group record passed from the
// accumulate front to the reduce back.
// ----------------------------------------------------------------------------
package asa_pkg;

    localparam int SAMPLE_BITS     = 16;
    localparam int READING_W       = SAMPLE_BITS;
    localparam int COUNT_W         = 8;
    localparam int SUM_W           = 24;
    localparam int MODE_W          = 2;
    localparam int MAX_SAMPLES_DEF = 255;
    localparam int QUEUE_DEPTH     = 2;

    typedef enum logic [MODE_W-1:0] {
        MODE_AVG    = 2'd0,
        MODE_MIN    = 2'd1,
        MODE_MAX    = 2'd2,
        MODE_UNUSED = 2'd3
    } mode_t;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] sample;
        logic                   final_sample;
    } sample_req_t;

    typedef struct packed {
        logic [READING_W-1:0] reading;
        logic [COUNT_W-1:0]   group_size;
    } reading_req_t;

    // One closed group: rule, running value and sample count
    typedef struct packed {
        mode_t              mode;
        logic [SUM_W-1:0]   value;
        logic [COUNT_W-1:0] count;
    } group_t;

    typedef struct packed {
        logic   valid;
        group_t group;
    } group_push_t;

    typedef struct packed {
        mode_t              mode;
        logic [COUNT_W-1:0] tally;
    } front_status_t;

endpackage

// ----- design/asa_stream_if.sv -----
// ----------------------------------------------------------------------------
// asa_stream_if: valid/ready request channel
// Generic payload type; source drives valid and payload, sink drives ready.
// ----------------------------------------------------------------------------
interface asa_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ----- design/adc_sample_aggregator_unit.sv -----
// ----------------------------------------------------------------------------
// adc_sample_aggregator_unit: oversampling average / min / max aggregator
// Folds a group of raw converter samples into one reading per group.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : sample requests {sample, final_sample}, valid/ready.
//   out_ch : reading requests {reading, group_size}, valid/ready.
//   cfg_we / cfg_wdata : mode write (0 avg, 1 min, 2 max). Write only when
//            idle; the open group is dropped and restarted under the new mode.
//   A group closes on final_sample or when it reaches MAX_SAMPLES samples.
// Throughput: one sample per cycle into the accumulate front while the queue
//   has room. A closed group sits in a 2-entry queue; the back reduces one
//   group at a time.
// Average mode path from the closing sample to out_ch.valid: queue pop,
//   bit-serial divider with one quotient bit per cycle, output register
//   load; min/max mode skips the divider. Groups that close faster than
//   the back reduces them fill the queue, and in_ch.ready drops until the
//   back frees an entry.
// Reset: mode is average, the group is empty, queue and output are empty.
// Receiver stall: the reading waits in the output register; the back holds
//   the next result, then the queue fills, then in_ch.ready goes low.
// ----------------------------------------------------------------------------
module adc_sample_aggregator_unit #(
    parameter int MAX_SAMPLES = asa_pkg::MAX_SAMPLES_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    asa_stream_if.sink                 in_ch,
    asa_stream_if.source               out_ch,
    input  logic                       cfg_we,
    input  logic [asa_pkg::MODE_W-1:0] cfg_wdata
);
    import asa_pkg::*;

    group_push_t   push;
    group_t        head;
    front_status_t front_status;
    logic          q_full;
    logic          q_empty;
    logic          q_pop;

    // accumulate front: sum / min / max and tally
    asa_front #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .q_full    (q_full),
        .push      (push),
        .status    (front_status)
    );

    // decouples sample intake from the slow divide
    asa_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (q_pop),
        .head  (head),
        .empty (q_empty),
        .full  (q_full)
    );

    // reduce back: rounded divide or pass-through, output register
    asa_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .empty  (q_empty),
        .pop    (q_pop),
        .out_ch (out_ch)
    );

    // a delivered reading always covers at least one sample
    assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> (out_ch.payload.group_size != '0))
    else $error("reading with empty group");

    // no group larger than the cap
    assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> (out_ch.payload.group_size <= COUNT_W'(MAX_SAMPLES)))
    else $error("group size above cap");

    // a mode write restarts the group
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> (front_status.tally == '0))
    else $error("tally not cleared by mode write");

    // a closing sample is only taken when the queue has room
    assert property (@(posedge clk) disable iff (!rst_n)
        push.valid |-> !q_full)
    else $error("group pushed into full queue");

endmodule

// ----- design/asa_front.sv -----
// ----------------------------------------------------------------------------
// asa_front: sample accumulate front
// Takes one sample request per cycle while the queue has room, updates
// sum/min/max and tally, and pushes a closed group into the queue.
// ----------------------------------------------------------------------------
module asa_front #(
    parameter int MAX_SAMPLES = asa_pkg::MAX_SAMPLES_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    asa_stream_if.sink                 in_ch,
    input  logic                       cfg_we,
    input  logic [asa_pkg::MODE_W-1:0] cfg_wdata,
    input  logic                       q_full,
    output asa_pkg::group_push_t       push,
    output asa_pkg::front_status_t     status
);
    import asa_pkg::*;

    mode_t              mode_reg;
    logic [SUM_W-1:0]   value_reg;
    logic [COUNT_W-1:0] tally_reg;

    logic [SUM_W-1:0]   value_upd;
    logic [SUM_W-1:0]   sample_ext;
    logic [COUNT_W-1:0] tally_inc;
    logic               accept;
    logic               close;

    function automatic logic [SUM_W-1:0] start_value(input mode_t m);
        logic [SUM_W-1:0] v;
        v = '0;
        if (m == MODE_MIN)
        begin
            v[SAMPLE_BITS-1:0] = '1;
        end
        return v;
    endfunction

    assign in_ch.ready = !q_full;
    assign accept      = in_ch.valid && in_ch.ready;
    assign sample_ext  = SUM_W'(in_ch.payload.sample);
    assign tally_inc   = tally_reg + COUNT_W'(1);
    assign close       = in_ch.payload.final_sample || (tally_inc == COUNT_W'(MAX_SAMPLES));

    always_comb
    begin
        value_upd = value_reg;
        case (mode_reg)
            MODE_AVG: value_upd = value_reg + sample_ext;
            MODE_MIN: if (sample_ext < value_reg) value_upd = sample_ext;
            MODE_MAX: if (sample_ext > value_reg) value_upd = sample_ext;
            default:  value_upd = value_reg;
        endcase
    end

    assign push.valid       = accept && close;
    assign push.group.mode  = mode_reg;
    assign push.group.value = value_upd;
    assign push.group.count = tally_inc;

    assign status.mode  = mode_reg;
    assign status.tally = tally_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_AVG;
            value_reg <= '0;
            tally_reg <= '0;
        end
        else if (cfg_we)
        begin
            // new mode drops the open group
            mode_reg  <= mode_t'(cfg_wdata);
            value_reg <= start_value(mode_t'(cfg_wdata));
            tally_reg <= '0;
        end
        else if (accept)
        begin
            if (close)
            begin
                value_reg <= start_value(mode_reg);
                tally_reg <= '0;
            end
            else
            begin
                value_reg <= value_upd;
                tally_reg <= tally_inc;
            end
        end
    end

endmodule

// ----- design/asa_queue.sv -----
// ----------------------------------------------------------------------------
// asa_queue: closed-group queue
// Small register FIFO between the accumulate front and the reduce back.
// ----------------------------------------------------------------------------
module asa_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  asa_pkg::group_push_t push,
    input  logic                 pop,
    output asa_pkg::group_t      head,
    output logic                 empty,
    output logic                 full
);
    import asa_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    group_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               do_push;
    logic               do_pop;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign head    = entry_reg[rd_ptr_reg];
    assign do_push = push.valid && !full;
    assign do_pop  = pop && !empty;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push.group;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + CNT_W'(1);
                2'b01:   count_reg <= count_reg - CNT_W'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

// ----- design/asa_back.sv -----
// ----------------------------------------------------------------------------
// asa_back: group reduce back
// Pops a closed group, divides the rounded sum by the count one quotient bit
// per cycle in average mode, and holds the reading in the output register.
// ----------------------------------------------------------------------------
module asa_back (
    input  logic            clk,
    input  logic            rst_n,
    input  asa_pkg::group_t head,
    input  logic            empty,
    output logic            pop,
    asa_stream_if.source    out_ch
);
    import asa_pkg::*;

    localparam int STEP_W = $clog2(SUM_W);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_DELIVER
    } state_t;

    state_t               state_reg;
    logic [SUM_W-1:0]     num_reg;
    logic [COUNT_W-1:0]   den_reg;
    logic [COUNT_W-1:0]   rem_reg;
    logic [STEP_W-1:0]    step_reg;
    logic [READING_W-1:0] res_reg;
    logic [COUNT_W-1:0]   size_reg;
    logic                 out_valid_reg;
    logic [READING_W-1:0] out_reading_reg;
    logic [COUNT_W-1:0]   out_size_reg;

    logic [COUNT_W:0]     rem_sh;
    logic                 rem_ge;
    logic [COUNT_W-1:0]   rem_next;
    logic [SUM_W-1:0]     num_next;
    logic                 deliver;

    // restoring division step: quotient bits shift into num from the bottom
    always_comb
    begin
        rem_sh   = {rem_reg, num_reg[SUM_W-1]};
        rem_ge   = (rem_sh >= {1'b0, den_reg});
        rem_next = rem_ge ? COUNT_W'(rem_sh - {1'b0, den_reg}) : rem_sh[COUNT_W-1:0];
        num_next = {num_reg[SUM_W-2:0], rem_ge};
    end

    assign pop     = (state_reg == ST_IDLE) && !empty;
    // output register is free or being drained this cycle
    assign deliver = (state_reg == ST_DELIVER) && (!out_valid_reg || out_ch.ready);

    assign out_ch.valid              = out_valid_reg;
    assign out_ch.payload.reading    = out_reading_reg;
    assign out_ch.payload.group_size = out_size_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (deliver)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (!empty)
                    begin
                        size_reg <= head.count;
                        case (head.mode) inside
                            MODE_AVG:
                            begin
                                num_reg   <= head.value + SUM_W'(head.count >> 1);
                                den_reg   <= head.count;
                                rem_reg   <= '0;
                                step_reg  <= STEP_W'(SUM_W - 1);
                                state_reg <= ST_DIVIDE;
                            end
                            MODE_MIN, MODE_MAX:
                            begin
                                res_reg   <= head.value[READING_W-1:0];
                                state_reg <= ST_DELIVER;
                            end
                            default:
                            begin
                                res_reg   <= '0;
                                state_reg <= ST_DELIVER;
                            end
                        endcase
                    end
                end
                ST_DIVIDE:
                begin
                    num_reg <= num_next;
                    rem_reg <= rem_next;
                    if (step_reg == '0)
                    begin
                        res_reg   <= num_next[READING_W-1:0];
                        state_reg <= ST_DELIVER;
                    end
                    else
                    begin
                        step_reg <= step_reg - STEP_W'(1);
                    end
                end
                ST_DELIVER:
                begin
                    if (deliver)
                    begin
                        out_reading_reg <= res_reg;
                        out_size_reg    <= size_reg;
                        state_reg       <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the ADC sample aggregator
// Feeds sample requests (directed corners, then random groups under every
// mode) through the input channel and checks each reading request against an
// in-bench average/min/max predictor updated on every accepted sample.
// ----------------------------------------------------------------------------
module tb_top;

    import asa_pkg::*;

    localparam int GROUP_CAP  = MAX_SAMPLES_DEF;
    localparam int LONG_HOLD  = 300;   // receiver hold-off, cycles
    localparam int SETTLE_CYC = 40;    // back-end latency margin

    logic clk;
    logic rst_n;
    logic cfg_we    = 1'b0;
    logic [MODE_W-1:0] cfg_wdata = '0;

    asa_stream_if #(.payload_t(sample_req_t))  smp_if ();
    asa_stream_if #(.payload_t(reading_req_t)) rdg_if ();

    adc_sample_aggregator_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (smp_if.sink),
        .out_ch    (rdg_if.source),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // 100 MHz
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------
    sample_req_t  samples_pending[$];   // requests not yet offered
    reading_req_t readings_due[$];      // predicted readings, oldest first
    int           errors       = 0;
    bit           quiet        = 1'b0;  // no random idling on either side
    int           hold_ticket  = 0;     // bumped to ask for a long hold-off
    int           holds_served = 0;
    int           hold_left    = 0;
    reading_req_t want;

    // Predictor state: current rule, running sum/min/max and sample count
    mode_t        cur_mode;
    logic [23:0]  run_value;
    logic [7:0]   sample_tally;

    // Empty group under the current rule; min starts from all ones
    function automatic void restart_group();
        run_value    = (cur_mode == MODE_MIN) ? 24'((1 << SAMPLE_BITS) - 1) : 24'd0;
        sample_tally = '0;
    endfunction

    // Fold one accepted sample in; queue a reading when the group closes
    function automatic void fold_sample(sample_req_t r);
        reading_req_t res;
        int unsigned  rounded;
        sample_tally = sample_tally + 8'd1;
        case (cur_mode)
            MODE_AVG: run_value = run_value + 24'(r.sample);
            MODE_MIN: if (24'(r.sample) < run_value) run_value = 24'(r.sample);
            MODE_MAX: if (24'(r.sample) > run_value) run_value = 24'(r.sample);
            default:  ;
        endcase
        if (r.final_sample || sample_tally >= GROUP_CAP)
        begin
            case (cur_mode)
                MODE_AVG:
                begin
                    // round to nearest, halves up
                    rounded     = int'(run_value) + int'(sample_tally >> 1);
                    res.reading = READING_W'(rounded / int'(sample_tally));
                end
                MODE_UNUSED: res.reading = '0;
                default:     res.reading = run_value[READING_W-1:0];
            endcase
            res.group_size = sample_tally;
            readings_due.push_back(res);
            restart_group();
        end
    endfunction

    // ------------------------------------------------------------------
    // Sample driver: keeps valid up across back-to-back requests, idles
    // about 15 percent of the time unless quiet is set.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            smp_if.valid <= 1'b0;
        end
        else if (!smp_if.valid || smp_if.ready)
        begin
            if (samples_pending.size() != 0 && (quiet || $urandom_range(99) >= 15))
            begin
                smp_if.valid   <= 1'b1;
                smp_if.payload <= samples_pending.pop_front();
            end
            else
            begin
                smp_if.valid <= 1'b0;
            end
        end
    end

    // Predict on every accepted sample request
    always @(posedge clk)
    begin
        if (rst_n && smp_if.valid && smp_if.ready)
            fold_sample(smp_if.payload);
    end

    // ------------------------------------------------------------------
    // Reading receiver: random stalls, plus a long hold-off on request so
    // the result register, the group queue and then in_ch.ready back up.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rdg_if.ready <= 1'b0;
            hold_left    <= 0;
        end
        else if (holds_served != hold_ticket)
        begin
            holds_served <= hold_ticket;
            hold_left    <= LONG_HOLD;
            rdg_if.ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left    <= hold_left - 1;
            rdg_if.ready <= 1'b0;
        end
        else
        begin
            rdg_if.ready <= quiet || ($urandom_range(99) >= 15);
        end
    end

    // Compare every accepted reading with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && rdg_if.valid && rdg_if.ready)
        begin
            if (readings_due.size() == 0)
            begin
                $display("%0t: unexpected reading: actual reading=%h size=%0d", $time,
                         rdg_if.payload.reading, rdg_if.payload.group_size);
                errors++;
            end
            else
            begin
                want = readings_due.pop_front();
                if (rdg_if.payload.reading !== want.reading)
                begin
                    $display("%0t: reading mismatch: expected %h actual %h", $time,
                             want.reading, rdg_if.payload.reading);
                    errors++;
                end
                if (rdg_if.payload.group_size !== want.group_size)
                begin
                    $display("%0t: group_size mismatch: expected %0d actual %0d", $time,
                             want.group_size, rdg_if.payload.group_size);
                    errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic send(logic [SAMPLE_BITS-1:0] s, logic fin);
        sample_req_t r;
        r.sample       = s;
        r.final_sample = fin;
        samples_pending.push_back(r);
    endtask

    // Every offered request taken and every predicted reading seen
    task automatic wait_drained();
        @(negedge clk);
        while (samples_pending.size() != 0 || smp_if.valid || readings_due.size() != 0)
            @(negedge clk);
    endtask

    // Mode write drops the open group; wait out the back end first since a
    // partial group left behind produces no reading to wait on
    task automatic write_mode(mode_t m);
        wait_drained();
        repeat (SETTLE_CYC) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= m;
        @(posedge clk);
        cfg_we    <= 1'b0;
        cur_mode  = m;
        restart_group();
        @(negedge clk);
    endtask

    function automatic logic [SAMPLE_BITS-1:0] rand_sample();
        int pick;
        pick = $urandom_range(9);
        if (pick == 0)
            return '0;
        else if (pick == 1)
            return '1;
        return SAMPLE_BITS'($urandom());
    endfunction

    // Random groups; the last one may be cut short and left open
    task automatic queue_groups(int n_items, int short_only);
        int left;
        int len;
        int pick;
        logic fin;
        left = n_items;
        while (left > 0)
        begin
            pick = $urandom_range(99);
            if (short_only != 0 || pick < 70)
                len = $urandom_range(1, 6);
            else if (pick < 95 || left < 280)
                len = $urandom_range(7, 40);
            else
                len = $urandom_range(240, 280);   // may cross the size cap
            for (int k = 0; k < len && left > 0; k++)
            begin
                fin = (k == len - 1);
                // stray early flag now and then
                if ($urandom_range(99) < 3)
                    fin = 1'b1;
                send(rand_sample(), fin);
                left--;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        mode_t m;
        smp_if.valid   = 1'b0;
        smp_if.payload = '0;
        rdg_if.ready   = 1'b0;
        cur_mode       = MODE_AVG;
        restart_group();
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Average at reset: single-sample extremes, half rounding up
        send(16'hFFFF, 1'b1);
        send(16'h0000, 1'b1);
        send(16'h0001, 1'b0);
        send(16'h0002, 1'b1);
        send(16'hFFFF, 1'b0);
        send(16'hFFFE, 1'b1);

        // Minimum: starts from all ones
        write_mode(MODE_MIN);
        send(16'h0005, 1'b0);
        send(16'hFFFF, 1'b0);
        send(16'h0003, 1'b1);
        send(16'hFFFF, 1'b1);

        // Maximum
        write_mode(MODE_MAX);
        send(16'h0000, 1'b1);
        send(16'h0007, 1'b0);
        send(16'h8000, 1'b1);

        // Open group discarded by a mode change, then the unused mode
        send(16'd100, 1'b0);
        send(16'd200, 1'b0);
        write_mode(MODE_UNUSED);
        send(16'h1234, 1'b0);
        send(16'hFFFF, 1'b1);

        // Size cap with the largest sum: 255 full-scale samples, no flag
        write_mode(MODE_AVG);
        for (int k = 0; k < GROUP_CAP + 2; k++)
            send(16'hFFFF, 1'b0);
        send(16'h0000, 1'b1);

        // Random phases; first four walk all modes, then random modes
        for (int p = 0; p < 11; p++)
        begin
            m = (p < 4) ? mode_t'(p) : mode_t'($urandom_range(3));
            write_mode(m);
            if (p == 5)
            begin
                // back-pressure: long receiver hold while the sender streams
                // short groups with no idling
                quiet = 1'b1;
                hold_ticket++;
                queue_groups(60, 1);
            end
            else if (p == 6)
            begin
                quiet = 1'b1;
                queue_groups(20, 0);
            end
            else
            begin
                quiet = 1'b0;
                queue_groups(20, 0);
            end
            // sender pauses here until everything predicted has come out
            wait_drained();
        end
        quiet = 1'b0;

        wait_drained();
        repeat (SETTLE_CYC) @(posedge clk);
        if (errors == 0 && readings_due.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Watchdog
    initial
    begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
